@@ src/b64le_pkg.sv @@
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the symbol map for the base64 line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

   localparam int unsigned CHARS_MAX = 5;
   localparam int unsigned COUNT_W   = 3;

   localparam logic [7:0] PAD_CHAR        = 8'h3D;
   localparam logic [7:0] BREAK_CHAR_RST  = 8'd13;
   localparam logic [7:0] QUADS_LINE_RST  = 8'd19;

   // configuration register indexes
   localparam logic CSR_BREAK_CHAR     = 1'b0;
   localparam logic CSR_QUADS_PER_LINE = 1'b1;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } b64le_phase_type;

   typedef struct packed {
      b64le_phase_type phase;
      logic [3:0]      carry;
      logic [7:0]      lquads;
   } b64le_state_type;

   // characters for one input byte, first character in element 0
   typedef struct packed {
      logic [CHARS_MAX-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
      logic                      msg_end;
   } b64le_job_type;

   typedef struct packed {
      logic free;   // job register empty or emptying this cycle
   } b64le_emit_status_type;

   function automatic logic [7:0] b64le_sym(input logic [5:0] v);
      logic [7:0] ext;
      ext = {2'b00, v};
      if (v < 6'd26)      return ext + 8'h41;
      else if (v < 6'd52) return ext + 8'd71;   // 'a' - 26
      else if (v < 6'd62) return ext - 8'd4;    // '0' - 52
      else if (v == 6'd62) return 8'h2B;
      else                 return 8'h2F;
   endfunction

endpackage

@@ src/base64_line_encoder_core.sv @@
// An accepted byte is held in the input register, then moved into the character register that drives rsp.
// Throughput: one character per cycle on rsp while rsp_tready is high; a byte yields
// 1 to 5 characters, 4 per three-byte quad plus 1 per break.
// The single input register and the character register set that rate.
// Reset (synchronous): break character 13, 19 quads per line, encoder state
// cleared and both channels empty.
// ----------------------------------------------------------------------------
// base64_line_encoder_core
// Streaming base64 encoder with configurable line breaks and message flush.
// ----------------------------------------------------------------------------
module base64_line_encoder_core
   import b64le_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast,    // run_last
   output logic       rsp_tuser,    // [0] msg_end
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;
   logic [7:0]            break_char_ff, break_char_in;
   logic [7:0]            quads_ff, quads_in;
   b64le_state_type       state_ff, state_in;
   b64le_state_type       next_state;
   b64le_job_type         job;
   b64le_emit_status_type emit_status;
   logic                  move;
   logic                  accept;

   assign move       = in_valid_ff && emit_status.free;
   assign req_tready = !in_valid_ff || move;
   assign accept     = req_tvalid && req_tready;

   b64le_expand u_expand (
      .st             (state_ff),
      .in_byte        (in_byte_ff),
      .in_last        (in_last_ff),
      .break_char     (break_char_ff),
      .quads_per_line (quads_ff),
      .job            (job),
      .nst            (next_state)
   );

   b64le_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .job        (job),
      .status     (emit_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_last_in    = in_last_ff;
      state_in      = state_ff;
      break_char_in = break_char_ff;
      quads_in      = quads_ff;
      if (move) begin
         in_valid_in = 1'b0;
         state_in    = next_state;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BREAK_CHAR:     break_char_in = csr_wdata;
            CSR_QUADS_PER_LINE: quads_in      = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= '{phase: PHASE_0, carry: 4'd0, lquads: 8'd0};
         break_char_ff <= BREAK_CHAR_RST;
         quads_ff      <= QUADS_LINE_RST;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         break_char_ff <= break_char_in;
         quads_ff      <= quads_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   // end of message only on the final character of a byte
   a_msg_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("msg_end without run_last");

   // a final byte leaves the encoder state cleared
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      move && in_last_ff |=> state_ff.phase == PHASE_0 && state_ff.carry == 4'd0
                             && state_ff.lquads == 8'd0)
      else $error("state not cleared after final byte");

   // a held byte is never dropped while the character register is busy
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending byte lost");

endmodule

@@ src/b64le_expand.sv @@
// ----------------------------------------------------------------------------
// b64le_expand
// Turns one byte and the encoder state into its list of output characters
// and the next state.
// ----------------------------------------------------------------------------
module b64le_expand
   import b64le_pkg::*;
(
   input  b64le_state_type st,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   input  logic [7:0]      break_char,
   input  logic [7:0]      quads_per_line,
   output b64le_job_type   job,
   output b64le_state_type nst
);

   logic [8:0] cnt;
   logic [8:0] lim;
   logic       just_broke;

   always_comb begin
      cnt        = {1'b0, st.lquads} + 9'd1;
      lim        = (quads_per_line == 8'd0) ? 9'd256 : {1'b0, quads_per_line};
      just_broke = 1'b0;
      job        = '0;
      nst        = st;

      case (st.phase)
         PHASE_1: begin
            job.chars[0] = b64le_sym({st.carry[1:0], in_byte[7:4]});
            job.count    = 3'd1;
            nst.carry    = in_byte[3:0];
            nst.phase    = PHASE_2;
         end
         PHASE_2: begin
            job.chars[0] = b64le_sym({st.carry, in_byte[7:6]});
            job.chars[1] = b64le_sym(in_byte[5:0]);
            nst.carry    = 4'd0;
            nst.phase    = PHASE_0;
            if (cnt >= lim) begin
               job.chars[2] = break_char;
               job.count    = 3'd3;
               nst.lquads   = 8'd0;
               just_broke   = 1'b1;
            end else begin
               job.count    = 3'd2;
               nst.lquads   = cnt[7:0];
            end
         end
         default: begin
            job.chars[0] = b64le_sym(in_byte[7:2]);
            job.count    = 3'd1;
            nst.carry    = {2'b00, in_byte[1:0]};
            nst.phase    = PHASE_1;
         end
      endcase

      // flush; the padded cases start from one character, the aligned case from two or three
      if (in_last) begin
         case (nst.phase)
            PHASE_1: begin
               job.chars[1] = b64le_sym({nst.carry[1:0], 4'b0000});
               job.chars[2] = PAD_CHAR;
               job.chars[3] = PAD_CHAR;
               job.chars[4] = break_char;
               job.count    = 3'd5;
            end
            PHASE_2: begin
               job.chars[1] = b64le_sym({nst.carry, 2'b00});
               job.chars[2] = PAD_CHAR;
               job.chars[3] = break_char;
               job.count    = 3'd4;
            end
            default: begin
               if (!just_broke && nst.lquads != 8'd0) begin
                  job.chars[2] = break_char;
                  job.count    = 3'd3;
               end
            end
         endcase
         job.msg_end = 1'b1;
         nst         = '{phase: PHASE_0, carry: 4'd0, lquads: 8'd0};
      end
   end

endmodule

@@ src/b64le_emitter.sv @@
// ----------------------------------------------------------------------------
// b64le_emitter
// Holds the characters of one byte and hands them out one per transaction.
// ----------------------------------------------------------------------------
module b64le_emitter
   import b64le_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  b64le_job_type         job,
   output b64le_emit_status_type status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_char
   output logic                  rsp_tlast,   // run_last
   output logic                  rsp_tuser    // [0] msg_end
);

   logic                      valid_ff, valid_in;
   logic [COUNT_W-1:0]        left_ff, left_in;
   logic [CHARS_MAX-1:0][7:0] chars_ff, chars_in;
   logic                      msg_end_ff, msg_end_in;
   logic                      take;
   logic                      final_char;

   assign take        = valid_ff && rsp_tready;
   assign final_char  = (left_ff == 3'd1);
   assign status.free = !valid_ff || (take && final_char);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = chars_ff[0];
   assign rsp_tlast  = final_char;
   assign rsp_tuser  = msg_end_ff && final_char;

   always_comb begin
      valid_in   = valid_ff;
      left_in    = left_ff;
      chars_in   = chars_ff;
      msg_end_in = msg_end_ff;
      if (load) begin
         valid_in   = 1'b1;
         left_in    = job.count;
         chars_in   = job.chars;
         msg_end_in = job.msg_end;
      end else if (take) begin
         valid_in = !final_char;
         left_in  = left_ff - 3'd1;
         chars_in = {8'h00, chars_ff[CHARS_MAX-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff   <= chars_in;
      msg_end_ff <= msg_end_in;
   end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_line_encoder_core. Bytes are fed from a
// queue through a stream driver, every accepted byte is run through an
// in-bench encoder model, and each character leaving the block is compared
// against the oldest predicted one. Line length and break character are
// changed between phases, including mid-message and at both extremes.
// ----------------------------------------------------------------------------
module tb
   import b64le_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_BYTES = 32;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain_first;   // hold this byte back until all output is in
   } raw_byte_type;

   typedef struct {
      logic [7:0] ch;
      logic       run_last;
      logic       msg_end;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;    // [7:0] in_byte
   logic       req_tlast = 1'b0;     // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tlast;            // run_last
   logic       rsp_tuser;            // [0] msg_end
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = 8'h00;

   raw_byte_type  raw_bytes[$];
   enc_char_type  pending_chars[$];

   // encoder model state and configuration
   logic [7:0]      cfg_break = BREAK_CHAR_RST;
   logic [7:0]      cfg_qpl = QUADS_LINE_RST;
   b64le_phase_type enc_phase = PHASE_0;
   logic [3:0]      enc_carry = 4'h0;
   logic [7:0]      enc_quads = 8'h00;

   // traffic shaping, set between phases
   logic send_gaps = 1'b1;
   logic recv_gaps = 1'b1;
   logic holdoff_go = 1'b0;
   logic holdoff_seen = 1'b0;
   int   send_gap_left = 0;
   int   recv_gap_left = 0;
   int   holdoff_left = 0;

   int n_bytes = 0;
   int n_chars = 0;
   int n_msgs = 0;
   int n_csr = 0;
   int n_fail = 0;

   base64_line_encoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] base64_symbol(input logic [5:0] v);
      if (v <= 6'd25) return 8'h41 + v;
      if (v <= 6'd51) return 8'h61 + (v - 6'd26);
      if (v <= 6'd61) return 8'h30 + (v - 6'd52);
      return (v == 6'd62) ? 8'h2B : 8'h2F;
   endfunction

   task automatic encode_byte(input logic [7:0] b, input logic last);
      logic [7:0]    chars [5];
      int            n;
      logic          broke;
      int            limit;
      enc_char_type  e;
      n = 0;
      broke = 1'b0;
      case (enc_phase)
         PHASE_1: begin
            chars[n] = base64_symbol({enc_carry[1:0], b[7:4]}); n++;
            enc_carry = b[3:0];
            enc_phase = PHASE_2;
         end
         PHASE_2: begin
            limit = (cfg_qpl == 8'd0) ? 256 : int'(cfg_qpl);
            chars[n] = base64_symbol({enc_carry, b[7:6]}); n++;
            chars[n] = base64_symbol(b[5:0]); n++;
            enc_carry = 4'h0;
            enc_phase = PHASE_0;
            // a lowered limit still breaks on the next complete quad
            if (int'(enc_quads) + 1 >= limit) begin
               chars[n] = cfg_break; n++;
               enc_quads = 8'h00;
               broke = 1'b1;
            end else begin
               enc_quads = enc_quads + 8'd1;
            end
         end
         default: begin
            chars[n] = base64_symbol(b[7:2]); n++;
            enc_carry = {2'b00, b[1:0]};
            enc_phase = PHASE_1;
         end
      endcase
      if (last) begin
         if (enc_phase == PHASE_1) begin
            chars[n] = base64_symbol({enc_carry[1:0], 4'h0}); n++;
            chars[n] = PAD_CHAR; n++;
            chars[n] = PAD_CHAR; n++;
            chars[n] = cfg_break; n++;
         end else if (enc_phase == PHASE_2) begin
            chars[n] = base64_symbol({enc_carry, 2'b00}); n++;
            chars[n] = PAD_CHAR; n++;
            chars[n] = cfg_break; n++;
         end else if (!broke && enc_quads != 8'h00) begin
            chars[n] = cfg_break; n++;
         end
         enc_phase = PHASE_0;
         enc_carry = 4'h0;
         enc_quads = 8'h00;
      end
      for (int i = 0; i < n; i++) begin
         e.ch = chars[i];
         e.run_last = (i == n - 1);
         e.msg_end = last && (i == n - 1);
         pending_chars.push_back(e);
      end
   endtask

   // stream driver
   always @(posedge clock) begin : drive_req
      raw_byte_type nxt;
      logic         offer;
      offer = req_tvalid;
      if (req_tvalid && req_tready) begin
         encode_byte(req_tdata, req_tlast);
         n_bytes++;
         offer = 1'b0;
         if (send_gaps && $urandom_range(0, 2) == 0) send_gap_left = gap_len() + 1;
      end
      if (!offer && !reset) begin
         if (send_gap_left > 0) begin
            send_gap_left--;
         end else if (raw_bytes.size() != 0 &&
                      !(raw_bytes[0].drain_first && pending_chars.size() != 0)) begin
            nxt = raw_bytes.pop_front();
            req_tdata <= nxt.data;
            req_tlast <= nxt.last;
            offer = 1'b1;
         end
      end
      req_tvalid <= offer;
   end

   // receiver readiness, including the long hold-off
   always @(posedge clock) begin : drive_rsp_ready
      logic ready;
      ready = 1'b0;
      if (holdoff_go != holdoff_seen) begin
         holdoff_seen = holdoff_go;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (reset) begin
         ready = 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
      end else if (recv_gap_left > 0) begin
         recv_gap_left--;
      end else begin
         ready = 1'b1;
         if (recv_gaps && $urandom_range(0, 3) == 0) recv_gap_left = gap_len();
      end
      rsp_tready <= ready;
   end

   // output checker
   always @(posedge clock) begin : check_rsp
      enc_char_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_chars++;
         if (rsp_tuser) n_msgs++;
         if (pending_chars.size() == 0) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
               $display("unexpected character %h last %b end %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            e = pending_chars.pop_front();
            if (rsp_tdata !== e.ch || rsp_tlast !== e.run_last || rsp_tuser !== e.msg_end) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $display("mismatch at char %0d: expected %h last %b end %b, got %h %b %b",
                           n_chars, e.ch, e.run_last, e.msg_end,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic last, input logic drain);
      raw_byte_type r;
      r.data = data;
      r.last = last;
      r.drain_first = drain;
      raw_bytes.push_back(r);
   endtask

   task automatic queue_message(input int len, input logic close, input logic drain);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), close && (i == len - 1), drain && (i == 0));
   endtask

   function automatic int message_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 6);
      if (r < 90) return $urandom_range(7, 30);
      return $urandom_range(31, 90);
   endfunction

   // block is idle once every byte is in and every character is out
   task automatic wait_idle();
      do @(negedge clock);
      while (raw_bytes.size() != 0 || req_tvalid || pending_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BREAK_CHAR) cfg_break = val;
      else cfg_qpl = val;
      n_csr++;
      @(negedge clock);
   endtask

   task automatic queue_random_bytes(input int budget);
      int queued;
      int len;
      queued = 0;
      while (queued < budget) begin
         len = message_len();
         if (len > budget - queued) len = budget - queued;
         // occasionally leave the phase's final message open
         queue_message(len, (queued + len < budget) || ($urandom_range(0, 3) != 0),
                       $urandom_range(0, 19) == 0);
         queued += len;
      end
   endtask

   initial begin : sequence_main
      logic [7:0] brk;
      logic [7:0] qpl;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, one-, two- and three-byte flushes, plus/slash symbols
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0);
      push_byte(8'hFB, 1'b0, 1'b1);
      push_byte(8'hEF, 1'b0, 1'b0);
      push_byte(8'hBE, 1'b1, 1'b0);
      wait_idle();

      // one quad per line: break on every quad, no doubled closing break
      write_csr(CSR_BREAK_CHAR, 8'h0A);
      write_csr(CSR_QUADS_PER_LINE, 8'd1);
      push_byte(8'h4D, 1'b0, 1'b0);
      push_byte(8'h61, 1'b0, 1'b0);
      push_byte(8'h6E, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h80, 1'b0, 1'b0);
      push_byte(8'h01, 1'b1, 1'b0);
      wait_idle();

      // limit lowered below the quads already on the line
      write_csr(CSR_BREAK_CHAR, 8'hFF);
      write_csr(CSR_QUADS_PER_LINE, 8'd19);
      queue_message(9, 1'b0, 1'b0);
      wait_idle();
      write_csr(CSR_QUADS_PER_LINE, 8'd2);
      queue_message(4, 1'b1, 1'b0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         brk = 8'($urandom_range(0, 255));
         case (p)
            0: begin brk = BREAK_CHAR_RST; qpl = QUADS_LINE_RST; end
            1: qpl = 8'd1;
            2: qpl = 8'd2;
            3: begin brk = 8'h00; qpl = 8'd255; end
            4: begin brk = 8'hFF; qpl = 8'd0; end   // zero means 256 quads
            5: qpl = 8'd3;
            6: qpl = 8'($urandom_range(1, 8));
            default: qpl = 8'($urandom_range(1, 255));
         endcase
         send_gaps = (p != 5) && (p != 6);
         recv_gaps = (p != 2) && (p != 5);
         write_csr(CSR_BREAK_CHAR, brk);
         write_csr(CSR_QUADS_PER_LINE, qpl);
         queue_random_bytes(PHASE_BYTES);
         if (p == 5) holdoff_go = ~holdoff_go;   // sink stalls, input backs up
         wait_idle();
      end

      repeat (20) @(negedge clock);
      $display("encoded %0d bytes into %0d characters over %0d messages, %0d register writes",
               n_bytes, n_chars, n_msgs, n_csr);
      $display("line settings from 1 to 255 quads and zero, mid-line limit change, %0d-cycle %s",
               HOLDOFF_CYCLES, "sink hold-off");
      if (n_fail == 0) begin
         $display("base64_line_encoder_core test passed");
      end else begin
         $display("%0d mismatches", n_fail);
         $display("base64_line_encoder_core test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("timeout with %0d characters outstanding", pending_chars.size());
      $display("base64_line_encoder_core test failed");
      $finish;
   end

endmodule
